[hdl/tmdsd_pkg.sv]
// ============================================================================
// tmdsd_pkg: shared types and constants for the timed motor drive
// Counter widths, register indexes, command and direction codes, reset values.
// ============================================================================
package tmdsd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int PHASE_COUNT = 4;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);
    localparam int CFG_IDX_W   = 2;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [PHASE_W-1:0]     phase_t;
    typedef logic [1:0]             dir_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

    localparam cnt_t   CNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam phase_t PHASE_LAST = phase_t'(PHASE_COUNT - 1);
    localparam phase_t PHASE_A    = phase_t'(0);
    localparam phase_t PHASE_B    = phase_t'(PHASE_COUNT / 2);

    // Configuration register indexes
    localparam cfg_idx_t REG_DIRECTION = 2'd0;
    localparam cfg_idx_t REG_RUN_TICKS = 2'd1;
    localparam cfg_idx_t REG_STALL_LIM = 2'd2;
    localparam cfg_idx_t REG_BLANKING  = 2'd3;

    // Direction codes
    localparam dir_t DIR_FORWARD = 2'd0;
    localparam dir_t DIR_REVERSE = 2'd1;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Register reset values
    localparam dir_t RST_DIRECTION = DIR_FORWARD;
    localparam cnt_t RST_RUN_TICKS = cnt_t'(1000);
    localparam cnt_t RST_STALL_LIM = cnt_t'(8);
    localparam cnt_t RST_BLANKING  = cnt_t'(10);

endpackage

[hdl/timed_motor_drive_stall_detect.sv]
// ============================================================================
// timed_motor_drive_stall_detect: timed H-bridge drive with stall detection
// One result word per command word; tracks run length, coil phases and the
// feedback capture interval.
// ============================================================================
//
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and capture_value: a tick
//   (cmd 0) or a start (cmd 1). Every accepted word yields exactly one result
//   word on the output channel (out_valid/out_ready) with the bridge enable,
//   coil levels, remaining ticks, end/stall pulses and feedback statistics.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no word is in flight.
//   A word accepted on the input channel enters the input register, moves to
//   the result register once that is free or being taken, and is then offered
//   on the output channel. Throughput: one word per cycle while out_ready stays
//   high; the run state updates in a single pass of logic between the input
//   register and the result register.
//   Reset clears all run state and loads the register defaults (forward,
//   1000 run ticks, stall limit 8, blanking 10).
//   When the receiver stalls, the result register holds, the input register
//   fills, and then in_ready drops until the result is taken.
//
module timed_motor_drive_stall_detect
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  tmdsd_pkg::cnt_t       capture_value,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  drive_enable,
    output logic                  coil_a,
    output logic                  coil_b,
    output tmdsd_pkg::cnt_t       ticks_left,
    output logic                  run_ended,
    output logic                  stall_stop,
    output tmdsd_pkg::dir_t       end_direction,
    output tmdsd_pkg::cnt_t       pulse_count,
    output tmdsd_pkg::cnt_t       last_gap,
    output logic                  capture_seen,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  tmdsd_pkg::cfg_idx_t   cfg_index,
    input  tmdsd_pkg::cnt_t       cfg_data
);
    import tmdsd_pkg::*;

    // Configuration registers
    dir_t   direction_reg;
    cnt_t   run_ticks_reg;
    cnt_t   stall_limit_reg;
    cnt_t   blanking_reg;

    // Input register
    logic   s1_valid_reg;
    logic   s1_cmd_reg;
    cnt_t   s1_cap_reg;

    // Run state
    phase_t phase_reg,    phase_next;
    cnt_t   remaining_reg, remaining_next;
    logic   enable_reg,   enable_next;
    logic   coil_a_reg,   coil_a_next;
    logic   coil_b_reg,   coil_b_next;
    cnt_t   stored_cap_reg, stored_cap_next;
    cnt_t   gap_cnt_reg,  gap_cnt_next;
    cnt_t   gap_held_reg, gap_held_next;
    cnt_t   pulses_reg,   pulses_next;
    logic   seen_reg,     seen_next;
    logic   ended_next;
    logic   stalled_next;

    // Output register
    logic   out_valid_reg;
    logic   out_enable_reg;
    logic   out_coil_a_reg;
    logic   out_coil_b_reg;
    cnt_t   out_left_reg;
    logic   out_ended_reg;
    logic   out_stall_reg;
    dir_t   out_dir_reg;
    cnt_t   out_pulses_reg;
    cnt_t   out_gap_reg;
    logic   out_seen_reg;

    logic   s1_advance;
    cnt_t   rem_dec;
    cnt_t   blank_end;
    logic   past_blank;
    logic   cap_changed;

    // Advance the input register into the result register when it is free
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign cfg_ready  = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= RST_DIRECTION;
            run_ticks_reg   <= RST_RUN_TICKS;
            stall_limit_reg <= RST_STALL_LIM;
            blanking_reg    <= RST_BLANKING;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIRECTION: direction_reg   <= cfg_data[1:0];
                REG_RUN_TICKS: run_ticks_reg   <= cfg_data;
                REG_STALL_LIM: stall_limit_reg <= cfg_data;
                REG_BLANKING:  blanking_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Hold the accepted word until it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg <= cmd;
            s1_cap_reg <= capture_value;
        end
    end

    // Blanking window check on the decremented count
    assign rem_dec     = remaining_reg - cnt_t'(1);
    assign blank_end   = run_ticks_reg - blanking_reg;
    assign past_blank  = (blanking_reg < run_ticks_reg) && (rem_dec < blank_end);
    assign cap_changed = (stored_cap_reg != s1_cap_reg);

    // Compute the next run state for the word in the input register
    always_comb
    begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        enable_next     = enable_reg;
        coil_a_next     = coil_a_reg;
        coil_b_next     = coil_b_reg;
        stored_cap_next = stored_cap_reg;
        gap_cnt_next    = gap_cnt_reg;
        gap_held_next   = gap_held_reg;
        pulses_next     = pulses_reg;
        seen_next       = seen_reg;
        ended_next      = 1'b0;
        stalled_next    = 1'b0;

        if (s1_cmd_reg == CMD_START)
        begin
            remaining_next = run_ticks_reg;
            enable_next    = (run_ticks_reg != '0);
            seen_next      = 1'b0;
        end
        else if (remaining_reg != '0)
        begin
            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + phase_t'(1);

            // Toggle coils by direction; other codes leave them alone
            if (direction_reg == DIR_FORWARD)
            begin
                if (phase_next == PHASE_A)
                    coil_a_next = !coil_a_reg;
                else if (phase_next == PHASE_B)
                    coil_b_next = !coil_b_reg;
            end
            else if (direction_reg == DIR_REVERSE)
            begin
                if (phase_next == PHASE_A)
                    coil_b_next = !coil_b_reg;
                else if (phase_next == PHASE_B)
                    coil_a_next = !coil_a_reg;
            end

            remaining_next = rem_dec;
            if (rem_dec == '0)
            begin
                enable_next = 1'b0;
                pulses_next = '0;
                ended_next  = 1'b1;
            end

            // Latch the feedback interval on a capture change
            if (cap_changed)
            begin
                stored_cap_next = s1_cap_reg;
                gap_held_next   = gap_cnt_reg;
                seen_next       = 1'b1;
                if (past_blank)
                begin
                    if (gap_cnt_reg < stall_limit_reg)
                    begin
                        enable_next    = 1'b0;
                        pulses_next    = '0;
                        remaining_next = '0;
                        ended_next     = 1'b1;
                        stalled_next   = 1'b1;
                    end
                    else if (pulses_next != CNT_MAX)
                    begin
                        pulses_next = pulses_next + cnt_t'(1);
                    end
                end
                gap_cnt_next = cnt_t'(1);
            end
            else if (gap_cnt_reg != CNT_MAX)
            begin
                gap_cnt_next = gap_cnt_reg + cnt_t'(1);
            end
        end
    end

    // Commit run state and result flag when the word advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            remaining_reg  <= '0;
            enable_reg     <= 1'b0;
            coil_a_reg     <= 1'b0;
            coil_b_reg     <= 1'b0;
            stored_cap_reg <= '0;
            gap_cnt_reg    <= '0;
            gap_held_reg   <= '0;
            pulses_reg     <= '0;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                phase_reg      <= phase_next;
                remaining_reg  <= remaining_next;
                enable_reg     <= enable_next;
                coil_a_reg     <= coil_a_next;
                coil_b_reg     <= coil_b_next;
                stored_cap_reg <= stored_cap_next;
                gap_cnt_reg    <= gap_cnt_next;
                gap_held_reg   <= gap_held_next;
                pulses_reg     <= pulses_next;
                seen_reg       <= seen_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_enable_reg <= enable_next;
            out_coil_a_reg <= coil_a_next;
            out_coil_b_reg <= coil_b_next;
            out_left_reg   <= remaining_next;
            out_ended_reg  <= ended_next;
            out_stall_reg  <= stalled_next;
            out_dir_reg    <= ended_next ? direction_reg : DIR_FORWARD;
            out_pulses_reg <= pulses_next;
            out_gap_reg    <= gap_held_next;
            out_seen_reg   <= seen_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_enable  = out_enable_reg;
    assign coil_a        = out_coil_a_reg;
    assign coil_b        = out_coil_b_reg;
    assign ticks_left    = out_left_reg;
    assign run_ended     = out_ended_reg;
    assign stall_stop    = out_stall_reg;
    assign end_direction = out_dir_reg;
    assign pulse_count   = out_pulses_reg;
    assign last_gap      = out_gap_reg;
    assign capture_seen  = out_seen_reg;

    // The bridge is never enabled with no ticks left
    a_enable_needs_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!drive_enable || ticks_left != '0))
        else $error("drive enabled with zero ticks left");

    // A stall stop is always an end of run, with the counter cleared
    a_stall_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stall_stop) |-> (run_ended && ticks_left == '0 && !drive_enable))
        else $error("stall stop without a full run end");

    // A run end drops the bridge and clears the count
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_ended) |-> (!drive_enable && ticks_left == '0))
        else $error("run end with bridge still enabled");

    // The enable state never outlives the run counter
    a_state_enable: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg |-> (remaining_reg != '0))
        else $error("enable state set with zero remaining");

    // A stalled result holds the input register full
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && s1_valid_reg) |=> s1_valid_reg)
        else $error("input register dropped a word during a stall");

endmodule

[dv/tmdsd_drive_checker.sv]
// ============================================================================
// tmdsd_drive_checker: result predictor and scoreboard for the motor drive
// Watches the command, result and register channels, keeps its own copy of
// the run state and registers, predicts one result word per command word and
// compares every taken result word against the oldest prediction.
// ============================================================================
module tmdsd_drive_checker
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  cmd,
    input  tmdsd_pkg::cnt_t       capture_value,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  drive_enable,
    input  logic                  coil_a,
    input  logic                  coil_b,
    input  tmdsd_pkg::cnt_t       ticks_left,
    input  logic                  run_ended,
    input  logic                  stall_stop,
    input  tmdsd_pkg::dir_t       end_direction,
    input  tmdsd_pkg::cnt_t       pulse_count,
    input  tmdsd_pkg::cnt_t       last_gap,
    input  logic                  capture_seen,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  tmdsd_pkg::cfg_idx_t   cfg_index,
    input  tmdsd_pkg::cnt_t       cfg_data,

    output int                    pending,
    output int                    mismatches,
    output int                    words_checked,
    output int                    run_ends,
    output int                    stall_stops
);
    import tmdsd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic drive_enable;
        logic coil_a;
        logic coil_b;
        cnt_t ticks_left;
        logic run_ended;
        logic stall_stop;
        dir_t end_direction;
        cnt_t pulse_count;
        cnt_t last_gap;
        logic capture_seen;
    } drive_word_t;

    // register copies
    dir_t   drive_dir;
    cnt_t   run_len;
    cnt_t   stall_lim;
    cnt_t   blank_len;

    // run state copies
    phase_t ph;
    cnt_t   ticks_rem;
    logic   bridge_on;
    logic   lvl_a;
    logic   lvl_b;
    cnt_t   cap_held;
    cnt_t   gap_cnt;
    cnt_t   gap_latched;
    cnt_t   pulse_tally;
    logic   change_seen;

    drive_word_t expected_words[$];
    drive_word_t got_word;
    drive_word_t want_word;

    function automatic string fmt_drive(input drive_word_t w);
        return $sformatf({"en=%0b a=%0b b=%0b left=%0d end=%0b stall=%0b dir=%0d",
                          " pulses=%0d gap=%0d seen=%0b"},
                         w.drive_enable, w.coil_a, w.coil_b, w.ticks_left,
                         w.run_ended, w.stall_stop, w.end_direction,
                         w.pulse_count, w.last_gap, w.capture_seen);
    endfunction

    // Advance the drive state by one command word and return its result word
    function automatic drive_word_t step_drive(input logic word_cmd, input cnt_t cap);
        drive_word_t r;
        logic        ended;
        logic        stalled;
        ended   = 1'b0;
        stalled = 1'b0;
        if (word_cmd == CMD_START) begin
            ticks_rem   = run_len;
            bridge_on   = (run_len != '0);
            change_seen = 1'b0;
        end else if (ticks_rem != '0) begin
            ph = (ph == PHASE_LAST) ? PHASE_A : phase_t'(ph + 1'b1);
            // toggle coils by direction, other codes leave both alone
            if (drive_dir == DIR_FORWARD) begin
                if (ph == PHASE_A)
                    lvl_a = ~lvl_a;
                else if (ph == PHASE_B)
                    lvl_b = ~lvl_b;
            end else if (drive_dir == DIR_REVERSE) begin
                if (ph == PHASE_A)
                    lvl_b = ~lvl_b;
                else if (ph == PHASE_B)
                    lvl_a = ~lvl_a;
            end
            ticks_rem = ticks_rem - 1'b1;
            if (ticks_rem == '0) begin
                bridge_on   = 1'b0;
                pulse_tally = '0;
                ended       = 1'b1;
            end
            // latch the interval on a capture change, check stall past blanking
            if (cap_held != cap) begin
                cap_held    = cap;
                gap_latched = gap_cnt;
                gap_cnt     = '0;
                change_seen = 1'b1;
                if (blank_len < run_len && ticks_rem < cnt_t'(run_len - blank_len)) begin
                    if (gap_latched < stall_lim) begin
                        bridge_on   = 1'b0;
                        pulse_tally = '0;
                        ticks_rem   = '0;
                        ended       = 1'b1;
                        stalled     = 1'b1;
                    end else if (pulse_tally != CNT_MAX) begin
                        pulse_tally = pulse_tally + 1'b1;
                    end
                end
            end
            if (gap_cnt != CNT_MAX)
                gap_cnt = gap_cnt + 1'b1;
        end
        r.drive_enable  = bridge_on;
        r.coil_a        = lvl_a;
        r.coil_b        = lvl_b;
        r.ticks_left    = ticks_rem;
        r.run_ended     = ended;
        r.stall_stop    = stalled;
        r.end_direction = ended ? drive_dir : dir_t'(0);
        r.pulse_count   = pulse_tally;
        r.last_gap      = gap_latched;
        r.capture_seen  = change_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drive_dir     = RST_DIRECTION;
            run_len       = RST_RUN_TICKS;
            stall_lim     = RST_STALL_LIM;
            blank_len     = RST_BLANKING;
            ph            = '0;
            ticks_rem     = '0;
            bridge_on     = 1'b0;
            lvl_a         = 1'b0;
            lvl_b         = 1'b0;
            cap_held      = '0;
            gap_cnt       = '0;
            gap_latched   = '0;
            pulse_tally   = '0;
            change_seen   = 1'b0;
            expected_words.delete();
            mismatches    = 0;
            words_checked = 0;
            run_ends      = 0;
            stall_stops   = 0;
            pending      <= 0;
        end else begin
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DIRECTION: drive_dir = cfg_data[1:0];
                    REG_RUN_TICKS: run_len   = cfg_data;
                    REG_STALL_LIM: stall_lim = cfg_data;
                    REG_BLANKING:  blank_len = cfg_data;
                    default:       ;
                endcase
            end

            // compare each taken result word with the oldest prediction
            if (out_valid && out_ready) begin
                got_word.drive_enable  = drive_enable;
                got_word.coil_a        = coil_a;
                got_word.coil_b        = coil_b;
                got_word.ticks_left    = ticks_left;
                got_word.run_ended     = run_ended;
                got_word.stall_stop    = stall_stop;
                got_word.end_direction = end_direction;
                got_word.pulse_count   = pulse_count;
                got_word.last_gap      = last_gap;
                got_word.capture_seen  = capture_seen;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result word with none predicted: %s", fmt_drive(got_word));
                end else begin
                    want_word = expected_words.pop_front();
                    words_checked++;
                    if (want_word.run_ended)
                        run_ends++;
                    if (want_word.stall_stop)
                        stall_stops++;
                    if (got_word !== want_word) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result word %0d mismatch", words_checked);
                            $display("  expected %s", fmt_drive(want_word));
                            $display("  actual   %s", fmt_drive(got_word));
                        end
                    end
                end
            end

            // predict the result of each accepted command word
            if (in_valid && in_ready)
                expected_words.push_back(step_drive(cmd, capture_value));

            pending <= expected_words.size();
        end
    end

endmodule

[dv/timed_motor_drive_stall_detect_tb.sv]
// ============================================================================
// timed_motor_drive_stall_detect_tb: stimulus and verdict for the motor drive
// Drives directed command words and randomized runs under several register
// settings, with random gaps on both sides; the checker predicts and
// compares every result word.
// ============================================================================
module timed_motor_drive_stall_detect_tb;
    import tmdsd_pkg::*;

    localparam dir_t DIR_IDLE     = 2'd2;
    localparam dir_t DIR_IDLE_ALT = 2'd3;
    localparam int   MAX_WAIT     = 10;
    localparam int   SETTLE_CYCLES = 6;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic       cmd           = CMD_TICK;
    cnt_t       capture_value = '0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic       drive_enable;
    logic       coil_a;
    logic       coil_b;
    cnt_t       ticks_left;
    logic       run_ended;
    logic       stall_stop;
    dir_t       end_direction;
    cnt_t       pulse_count;
    cnt_t       last_gap;
    logic       capture_seen;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index     = REG_DIRECTION;
    cnt_t       cfg_data      = '0;

    int         pending;
    int         mismatches;
    int         words_checked;
    int         run_ends;
    int         stall_stops;

    bit         idle_on       = 1'b1;
    int         ready_hold    = 0;
    int         ready_draw;
    cnt_t       cur_cap       = '0;
    cnt_t       run_setting   = RST_RUN_TICKS;
    int         run_guess     = 0;
    int         settings_used = 1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    timed_motor_drive_stall_detect dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_enable  (drive_enable),
        .coil_a        (coil_a),
        .coil_b        (coil_b),
        .ticks_left    (ticks_left),
        .run_ended     (run_ended),
        .stall_stop    (stall_stop),
        .end_direction (end_direction),
        .pulse_count   (pulse_count),
        .last_gap      (last_gap),
        .capture_seen  (capture_seen),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tmdsd_drive_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_enable  (drive_enable),
        .coil_a        (coil_a),
        .coil_b        (coil_b),
        .ticks_left    (ticks_left),
        .run_ended     (run_ended),
        .stall_stop    (stall_stop),
        .end_direction (end_direction),
        .pulse_count   (pulse_count),
        .last_gap      (last_gap),
        .capture_seen  (capture_seen),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches),
        .words_checked (words_checked),
        .run_ends      (run_ends),
        .stall_stops   (stall_stops)
    );

    // Result side: with idle gaps on, hold ready low at random after a taken word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 1)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (ready_hold == 1)
        begin
            ready_hold <= 0;
            out_ready  <= 1'b1;
        end
        else if (!out_ready)
        begin
            out_ready <= 1'b1;
        end
        else if (out_valid && idle_on)
        begin
            ready_draw = $urandom_range(0, MAX_WAIT);
            if (ready_draw != 0)
            begin
                out_ready  <= 1'b0;
                ready_hold <= ready_draw;
            end
        end
    end

    // Offer one command word, keep valid high afterwards unless a gap follows
    task automatic send_word(input logic word_cmd, input cnt_t word_cap);
        int wait_cycles;
        wait_cycles = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (wait_cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= word_cmd;
        capture_value <= word_cap;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (word_cmd == CMD_START)
            run_guess = run_setting;
        else if (run_guess > 0)
            run_guess--;
    endtask

    // Stop offering words and wait until every predicted word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cnt_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic apply_setting(input dir_t dir, input cnt_t run_len,
                                 input cnt_t stall_lim, input cnt_t blank_len);
        drain_results();
        write_reg(REG_DIRECTION, cnt_t'(dir));
        write_reg(REG_RUN_TICKS, run_len);
        write_reg(REG_STALL_LIM, stall_lim);
        write_reg(REG_BLANKING, blank_len);
        cfg_valid   <= 1'b0;
        run_setting  = run_len;
        run_guess    = 0;
        settings_used++;
    endtask

    // Random runs: starts mostly once the run is over, captures change at random
    task automatic random_run(input int n_words, input int change_pct);
        int start_pct;
        for (int i = 0; i < n_words; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < change_pct)
                cur_cap = cnt_t'($urandom);
            start_pct = (run_guess == 0) ? 50 : 3;
            if ($urandom_range(0, 99) < start_pct)
                send_word(CMD_START, cur_cap);
            else
                send_word(CMD_TICK, cur_cap);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: tick while stopped, then changes inside blanking
        send_word(CMD_TICK, 16'hFFFF);
        send_word(CMD_START, 16'h0000);
        send_word(CMD_TICK, 16'hFFFF);
        send_word(CMD_TICK, 16'h0000);
        send_word(CMD_TICK, 16'hA5A5);

        // zero run length never enables the bridge
        apply_setting(DIR_FORWARD, 16'd0, 16'd8, 16'd10);
        send_word(CMD_START, 16'hA5A5);
        send_word(CMD_TICK, 16'h5A5A);

        // short reverse run: pulse, end with a change on the final tick
        apply_setting(DIR_REVERSE, 16'd6, 16'd2, 16'd1);
        send_word(CMD_START, 16'h0000);
        send_word(CMD_TICK, 16'h0000);
        send_word(CMD_TICK, 16'h0000);
        send_word(CMD_TICK, 16'h8000);
        send_word(CMD_TICK, 16'h8000);
        send_word(CMD_TICK, 16'h8000);
        send_word(CMD_TICK, 16'h1234);
        // quick changes right after blanking stop the run as stalled
        send_word(CMD_START, 16'h1234);
        send_word(CMD_TICK, 16'h4321);
        send_word(CMD_TICK, 16'h0F0F);
        // restart in the middle of a run
        send_word(CMD_START, 16'h0F0F);
        send_word(CMD_TICK, 16'h0F0F);
        send_word(CMD_START, 16'hF0F0);
        send_word(CMD_TICK, 16'hF0F0);
        cur_cap = 16'hF0F0;

        // randomized runs over a spread of settings
        apply_setting(DIR_FORWARD, 16'd40, 16'd3, 16'd5);
        random_run(150, 30);
        apply_setting(DIR_REVERSE, 16'd20, 16'd0, 16'd0);
        random_run(150, 45);
        apply_setting(DIR_IDLE, 16'd60, 16'd6, 16'hFFFF);
        random_run(150, 25);
        apply_setting(DIR_IDLE_ALT, 16'd1, 16'hFFFF, 16'd0);
        random_run(150, 50);
        apply_setting(dir_t'($urandom_range(0, 3)), cnt_t'($urandom_range(2, 80)),
                      cnt_t'($urandom_range(0, 8)), cnt_t'($urandom_range(0, 30)));
        random_run(150, $urandom_range(10, 60));
        apply_setting(dir_t'($urandom_range(0, 3)), cnt_t'($urandom_range(2, 80)),
                      cnt_t'($urandom_range(0, 8)), cnt_t'($urandom_range(0, 30)));
        random_run(150, $urandom_range(10, 60));
        apply_setting(DIR_FORWARD, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        random_run(150, 20);
        idle_on = 1'b1;

        drain_results();
        $display("covered %0d result words under %0d register settings,", words_checked,
                 settings_used);
        $display("%0d runs ended (%0d on stall), with and without idle gaps",
                 run_ends, stall_stops);
        if (mismatches == 0)
            $display("PASS timed_motor_drive_stall_detect");
        else
            $display("FAIL timed_motor_drive_stall_detect");
        $finish;
    end

    // Hard stop far past the slowest correct run
    initial
    begin
        #8_000_000;
        $display("FAIL timed_motor_drive_stall_detect");
        $finish;
    end

endmodule
